// ----- rtl/sip4_pkg.sv -----
package sip4_pkg;

  typedef enum logic [3:0] {
    MODE_DC = 4'd0,
    MODE_TM = 4'd1,
    MODE_VE = 4'd2,
    MODE_HE = 4'd3,
    MODE_LD = 4'd4,
    MODE_RD = 4'd5,
    MODE_VR = 4'd6,
    MODE_VL = 4'd7,
    MODE_HD = 4'd8,
    MODE_HU = 4'd9
  } pred_mode_e;

  typedef struct packed {
    logic [63:0] above_pixels;
    logic [31:0] left_pixels;
    logic [7:0]  corner_pixel;
    logic [3:0]  pred_mode;
  } sip4_in_t;

  typedef struct packed {
    logic [31:0] row0;
    logic [31:0] row1;
    logic [31:0] row2;
    logic [31:0] row3;
    logic        bad_mode;
  } sip4_out_t;

  // rounded two-tap average
  function automatic logic [7:0] avg2(logic [7:0] x, logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y} + 9'd1;
    return s[8:1];
  endfunction

  // rounded three-tap average, weights 1 2 1
  function automatic logic [7:0] avg3(logic [7:0] x, logic [7:0] y, logic [7:0] z);
    logic [9:0] s;
    s = {2'b00, x} + {1'b0, y, 1'b0} + {2'b00, z} + 10'd2;
    return s[9:2];
  endfunction

endpackage

// ----- rtl/subblock_intra_predict_4x4_core.sv -----
// 4x4 luma subblock intra predictor.
// Input channel: drive item_i and raise start for one cycle; the item is taken
// at the rising edge where start is high and busy is low. busy stays low, so
// a new item can be offered in every cycle.
// An item carries eight above pixels (four above, four above-right), four left
// pixels, the above-left corner pixel and a mode code (DC, TM, VE, HE, LD, RD,
// VR, VL, HD, HU). Codes above HU set bad_mode and give all-zero rows.
// Result channel: done_o is high for exactly one cycle with result_o valid in
// that same cycle; the receiver must take it then, it cannot stall the block.
// The result passes through two registers: the input register, then the result
// register. Nothing stalls the flow, so throughput is one item per cycle, set by
// the single combinational pass of 2- and 3-tap averages, the DC sum and the TM
// clamp between those two registers.
// Reset clears the valid flags of both stages; no item in flight survives it
// and no result strobe follows it.
module subblock_intra_predict_4x4_core import sip4_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  sip4_in_t  item_i,
  output logic      done_o,
  output sip4_out_t result_o
);

  logic      valid_q, valid_d;
  sip4_in_t  in_q;
  logic      done_q, done_d;
  sip4_out_t res_q, res_d;

  logic [7:0] a [8];
  logic [7:0] ax [9];
  logic [7:0] l [4];
  logic [7:0] e [9];
  logic [7:0] p;
  logic [7:0] b [4][4];
  logic [10:0] dc_sum;
  logic [7:0]  dc_val;

  assign busy    = 1'b0;
  assign valid_d = start && !busy;
  assign done_d  = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      in_q <= item_i;
    end
    if (valid_q) begin
      res_q <= res_d;
    end
  end

  // unpack edge pixels; e runs from bottom-left up through the corner and along the top
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      a[k]  = in_q.above_pixels[8*k +: 8];
      ax[k] = in_q.above_pixels[8*k +: 8];
    end
    ax[8] = in_q.above_pixels[63:56];
    for (int k = 0; k < 4; k++) begin
      l[k] = in_q.left_pixels[8*k +: 8];
    end
    p    = in_q.corner_pixel;
    e[0] = l[3];
    e[1] = l[2];
    e[2] = l[1];
    e[3] = l[0];
    e[4] = p;
    e[5] = a[0];
    e[6] = a[1];
    e[7] = a[2];
    e[8] = a[3];
  end

  always_comb begin
    dc_sum = 11'd4;
    for (int k = 0; k < 4; k++) begin
      dc_sum = dc_sum + {3'b000, a[k]} + {3'b000, l[k]};
    end
    dc_val = dc_sum[10:3];
  end

  always_comb begin
    logic [9:0] tm;
    logic       bad;
    tm  = '0;
    bad = 1'b0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        b[r][c] = '0;
      end
    end
    unique case (in_q.pred_mode)
      MODE_DC: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            b[r][c] = dc_val;
          end
        end
      end
      MODE_TM: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            tm = {2'b00, l[r]} + {2'b00, a[c]} - {2'b00, p};
            // clamp: sign bit means below zero, bit 8 means above 255
            if (tm[9]) begin
              b[r][c] = 8'd0;
            end else if (tm[8]) begin
              b[r][c] = 8'd255;
            end else begin
              b[r][c] = tm[7:0];
            end
          end
        end
      end
      MODE_VE: begin
        for (int r = 0; r < 4; r++) begin
          b[r][0] = avg3(p, a[0], a[1]);
          b[r][1] = avg3(a[0], a[1], a[2]);
          b[r][2] = avg3(a[1], a[2], a[3]);
          b[r][3] = avg3(a[2], a[3], a[4]);
        end
      end
      MODE_HE: begin
        for (int c = 0; c < 4; c++) begin
          b[0][c] = avg3(p, l[0], l[1]);
          b[1][c] = avg3(l[0], l[1], l[2]);
          b[2][c] = avg3(l[1], l[2], l[3]);
          b[3][c] = avg3(l[2], l[3], l[3]);
        end
      end
      MODE_LD: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            b[r][c] = avg3(ax[r+c], ax[r+c+1], ax[r+c+2]);
          end
        end
      end
      MODE_RD: begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 4; c++) begin
            b[r][c] = avg3(e[3-r+c], e[4-r+c], e[5-r+c]);
          end
        end
      end
      MODE_VR: begin
        b[3][0] = avg3(e[1], e[2], e[3]);
        b[2][0] = avg3(e[2], e[3], e[4]);
        b[3][1] = avg3(e[3], e[4], e[5]);
        b[1][0] = b[3][1];
        b[2][1] = avg2(e[4], e[5]);
        b[0][0] = b[2][1];
        b[3][2] = avg3(e[4], e[5], e[6]);
        b[1][1] = b[3][2];
        b[2][2] = avg2(e[5], e[6]);
        b[0][1] = b[2][2];
        b[3][3] = avg3(e[5], e[6], e[7]);
        b[1][2] = b[3][3];
        b[2][3] = avg2(e[6], e[7]);
        b[0][2] = b[2][3];
        b[1][3] = avg3(e[6], e[7], e[8]);
        b[0][3] = avg2(e[7], e[8]);
      end
      MODE_VL: begin
        b[0][0] = avg2(a[0], a[1]);
        b[1][0] = avg3(a[0], a[1], a[2]);
        b[2][0] = avg2(a[1], a[2]);
        b[0][1] = b[2][0];
        b[1][1] = avg3(a[1], a[2], a[3]);
        b[3][0] = b[1][1];
        b[2][1] = avg2(a[2], a[3]);
        b[0][2] = b[2][1];
        b[3][1] = avg3(a[2], a[3], a[4]);
        b[1][2] = b[3][1];
        b[2][2] = avg2(a[3], a[4]);
        b[0][3] = b[2][2];
        b[3][2] = avg3(a[3], a[4], a[5]);
        b[1][3] = b[3][2];
        b[2][3] = avg3(a[4], a[5], a[6]);
        b[3][3] = avg3(a[5], a[6], a[7]);
      end
      MODE_HD: begin
        b[3][0] = avg2(e[0], e[1]);
        b[3][1] = avg3(e[0], e[1], e[2]);
        b[2][0] = avg2(e[1], e[2]);
        b[3][2] = b[2][0];
        b[2][1] = avg3(e[1], e[2], e[3]);
        b[3][3] = b[2][1];
        b[2][2] = avg2(e[2], e[3]);
        b[1][0] = b[2][2];
        b[2][3] = avg3(e[2], e[3], e[4]);
        b[1][1] = b[2][3];
        b[1][2] = avg2(e[3], e[4]);
        b[0][0] = b[1][2];
        b[1][3] = avg3(e[3], e[4], e[5]);
        b[0][1] = b[1][3];
        b[0][2] = avg3(e[4], e[5], e[6]);
        b[0][3] = avg3(e[5], e[6], e[7]);
      end
      MODE_HU: begin
        b[0][0] = avg2(l[0], l[1]);
        b[0][1] = avg3(l[0], l[1], l[2]);
        b[0][2] = avg2(l[1], l[2]);
        b[1][0] = b[0][2];
        b[0][3] = avg3(l[1], l[2], l[3]);
        b[1][1] = b[0][3];
        b[1][2] = avg2(l[2], l[3]);
        b[2][0] = b[1][2];
        b[1][3] = avg3(l[2], l[3], l[3]);
        b[2][1] = b[1][3];
        b[2][2] = l[3];
        b[2][3] = l[3];
        for (int c = 0; c < 4; c++) begin
          b[3][c] = l[3];
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    res_d.row0     = {b[0][3], b[0][2], b[0][1], b[0][0]};
    res_d.row1     = {b[1][3], b[1][2], b[1][1], b[1][0]};
    res_d.row2     = {b[2][3], b[2][2], b[2][1], b[2][0]};
    res_d.row3     = {b[3][3], b[3][2], b[3][1], b[3][0]};
    res_d.bad_mode = bad;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // every accepted item yields a strobe once it has passed the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted item produced no result");

  // no strobe without an item accepted earlier and passed through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result strobe without accepted item");

  // an invalid mode gives all-zero rows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.bad_mode) |->
      (result_o.row0 == '0 && result_o.row1 == '0 &&
       result_o.row2 == '0 && result_o.row3 == '0))
    else $error("invalid mode produced nonzero prediction");

  // error flag follows the registered mode code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.bad_mode == ($past(in_q.pred_mode) > MODE_HU)))
    else $error("bad_mode does not match mode code");

endmodule
